/* rtl/core/tajt_pkg.sv */
// Shared types, codes and constants for the tick alarm and periodic job timer.
// Used by every module of the block; depends on nothing else.
package tajt_pkg;

    // Default sizes of the alarm and job banks
    localparam int DEF_NUM_ALARMS = 4;
    localparam int DEF_NUM_JOBS   = 4;

    // Job period registers that the configuration port provides
    localparam int CFG_JOB_SLOTS = 4;

    // Time constants
    localparam logic [9:0]  STEP_MAX       = 10'd1000;
    localparam logic [9:0]  TICK_RESET     = 10'd1000;
    localparam logic [10:0] US_PER_MS      = 11'd1000;
    localparam logic [9:0]  MS_WRAP        = 10'd1000;
    localparam logic [31:0] MS_PER_S       = 32'd1000;

    // Configuration register indexes
    localparam logic [2:0] CFG_TICK_PERIOD  = 3'd0;
    localparam logic [2:0] CFG_JOB_MASK     = 3'd1;
    localparam logic [2:0] CFG_JOB_PERIOD_0 = 3'd2;
    localparam logic [2:0] CFG_JOB_PERIOD_1 = 3'd3;
    localparam logic [2:0] CFG_JOB_PERIOD_2 = 3'd4;
    localparam logic [2:0] CFG_JOB_PERIOD_3 = 3'd5;

    // Poll status codes
    localparam logic [1:0] ST_RANG        = 2'd0;
    localparam logic [1:0] ST_NOT_RINGING = 2'd1;
    localparam logic [1:0] ST_BAD_ID      = 2'd2;

    // Operation codes
    typedef enum logic [2:0] {
        OP_TICK    = 3'd0,
        OP_SET     = 3'd1,
        OP_POLL    = 3'd2,
        OP_RESTART = 3'd3,
        OP_READ    = 3'd4,
        OP_CLEAR   = 3'd5
    } op_t;

    // Sequencer states
    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_WAIT,
        CS_DONE
    } ctrl_state_t;

    // Command issued by the sequencer to the banks
    typedef struct packed {
        logic        issue;
        logic        tick;
        logic        set_alarm;
        logic        poll;
        logic        restart;
        logic        clear;
        logic [3:0]  id;
        logic [31:0] duration;
        logic        in_seconds;
    } cmd_t;

    // Clamp the tick period so that at most one millisecond carries per tick
    function automatic logic [9:0] clamp_step(input logic [9:0] period);
        return (period > STEP_MAX) ? STEP_MAX : period;
    endfunction

endpackage

/* rtl/core/tick_alarm_and_periodic_job_timer_top.sv */
// Tick alarm and periodic job timer: top level with the configuration registers.
// Depends on tajt_pkg, tajt_ctrl, tajt_time_base, tajt_alarm_bank and tajt_job_bank.
//
// An operation is transferred when start is high and busy is low. Its result appears
// for exactly one cycle with done high; the receiver cannot stall it, so it must take
// jobs_fired, alarm_status, seconds_now and millis_now in that cycle. After the transfer,
// the sequencer goes from its execute state to its done state for set, restart, read,
// clear and unknown opcodes; a poll passes through the wait state while the alarm memory
// is read, and a tick waits there for the sweep that reads, updates and writes back one
// job counter a cycle. A new operation may be transferred in the cycle that done is high.
// The user must write configuration only while no operation is pending; not enforced.
module tick_alarm_and_periodic_job_timer_top #(
    parameter int NUM_ALARMS = tajt_pkg::DEF_NUM_ALARMS,
    parameter int NUM_JOBS   = tajt_pkg::DEF_NUM_JOBS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  opcode,
    input  logic [3:0]  slot_id,
    input  logic [31:0] duration,
    input  logic        in_seconds,
    output logic        done,
    output logic [3:0]  jobs_fired,
    output logic [1:0]  alarm_status,
    output logic [31:0] seconds_now,
    output logic [9:0]  millis_now,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_wdata
);
    import tajt_pkg::*;

    logic [9:0]  tick_period_reg;
    logic [3:0]  job_mask_reg;
    logic [31:0] job_period_reg [CFG_JOB_SLOTS];
    logic [9:0]  step;
    logic [31:0] total_ms;
    logic        sweep_busy;
    cmd_t        cmd;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_period_reg <= TICK_RESET;
            job_mask_reg    <= '0;
            for (int j = 0; j < CFG_JOB_SLOTS; j++)
            begin
                job_period_reg[j] <= '0;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_TICK_PERIOD:  tick_period_reg   <= cfg_wdata[9:0];
                CFG_JOB_MASK:     job_mask_reg      <= cfg_wdata[3:0];
                CFG_JOB_PERIOD_0: job_period_reg[0] <= cfg_wdata;
                CFG_JOB_PERIOD_1: job_period_reg[1] <= cfg_wdata;
                CFG_JOB_PERIOD_2: job_period_reg[2] <= cfg_wdata;
                CFG_JOB_PERIOD_3: job_period_reg[3] <= cfg_wdata;
                default:          job_mask_reg      <= job_mask_reg;
            endcase
        end
    end

    assign step = clamp_step(tick_period_reg);

    tajt_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .opcode     (opcode),
        .slot_id    (slot_id),
        .duration   (duration),
        .in_seconds (in_seconds),
        .sweep_busy (sweep_busy),
        .busy       (busy),
        .done       (done),
        .cmd        (cmd)
    );

    tajt_time_base u_time_base (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .step        (step),
        .seconds_now (seconds_now),
        .millis_now  (millis_now),
        .total_ms    (total_ms)
    );

    tajt_alarm_bank #(
        .NUM_ALARMS (NUM_ALARMS)
    ) u_alarm_bank (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .total_ms     (total_ms),
        .alarm_status (alarm_status)
    );

    tajt_job_bank #(
        .NUM_JOBS (NUM_JOBS)
    ) u_job_bank (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .step        (step),
        .enable_mask (job_mask_reg),
        .job_period  (job_period_reg),
        .sweep_busy  (sweep_busy),
        .jobs_fired  (jobs_fired)
    );

endmodule

/* rtl/core/tajt_time_base.sv */
// Time base: sub-millisecond accumulator, millisecond and second counters.
// Depends on tajt_pkg for the command struct and time constants.
module tajt_time_base (
    input  logic           clk,
    input  logic           rst_n,
    input  tajt_pkg::cmd_t cmd,
    input  logic [9:0]     step,
    output logic [31:0]    seconds_now,
    output logic [9:0]     millis_now,
    output logic [31:0]    total_ms
);
    import tajt_pkg::*;

    logic [10:0] accum_reg, accum_next;
    logic [9:0]  millis_reg, millis_next;
    logic [31:0] seconds_reg, seconds_next;
    logic [31:0] total_reg, total_next;
    logic [10:0] acc_sum;
    logic [9:0]  ms_inc;

    // Advance on a tick, drop everything on a clear
    always_comb
    begin
        accum_next   = accum_reg;
        millis_next  = millis_reg;
        seconds_next = seconds_reg;
        total_next   = total_reg;
        acc_sum      = accum_reg + 11'(step);
        ms_inc       = millis_reg + 10'd1;
        if (cmd.clear)
        begin
            accum_next   = '0;
            millis_next  = '0;
            seconds_next = '0;
            total_next   = '0;
        end
        else if (cmd.tick)
        begin
            if (acc_sum >= US_PER_MS)
            begin
                accum_next = acc_sum - US_PER_MS;
                total_next = total_reg + 32'd1;
                if (ms_inc == MS_WRAP)
                begin
                    millis_next  = '0;
                    seconds_next = seconds_reg + 32'd1;
                end
                else
                begin
                    millis_next = ms_inc;
                end
            end
            else
            begin
                accum_next = acc_sum;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accum_reg   <= '0;
            millis_reg  <= '0;
            seconds_reg <= '0;
            total_reg   <= '0;
        end
        else
        begin
            accum_reg   <= accum_next;
            millis_reg  <= millis_next;
            seconds_reg <= seconds_next;
            total_reg   <= total_next;
        end
    end

    assign seconds_now = seconds_reg;
    assign millis_now  = millis_reg;
    assign total_ms    = total_reg;

endmodule

/* rtl/core/tajt_alarm_bank.sv */
// Alarm bank: start time and length of each alarm in a one-port synchronous memory,
// armed flags in flip-flops. Depends on tajt_pkg for the command struct and codes.
module tajt_alarm_bank #(
    parameter int NUM_ALARMS = tajt_pkg::DEF_NUM_ALARMS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tajt_pkg::cmd_t cmd,
    input  logic [31:0]    total_ms,
    output logic [1:0]     alarm_status
);
    import tajt_pkg::*;

    localparam int AIDX_W = (NUM_ALARMS > 1) ? $clog2(NUM_ALARMS) : 1;

    typedef struct packed {
        logic [31:0] length;
        logic [31:0] start;
    } alarm_entry_t;

    alarm_entry_t    alarm_mem [NUM_ALARMS];
    alarm_entry_t    rd_entry_reg;
    logic            armed_reg [NUM_ALARMS];
    logic            poll_pend_reg;
    logic [1:0]      status_reg;
    logic            id_ok;
    logic [AIDX_W-1:0] aidx;
    logic [31:0]     len_in;
    logic [31:0]     elapsed;
    logic            rang;

    assign id_ok   = {1'b0, cmd.id} < 5'(NUM_ALARMS);
    assign aidx    = cmd.id[AIDX_W-1:0];
    assign len_in  = cmd.in_seconds ? 32'(cmd.duration * MS_PER_S) : cmd.duration;
    assign elapsed = total_ms - rd_entry_reg.start;
    assign rang    = poll_pend_reg && armed_reg[aidx] && (elapsed >= rd_entry_reg.length);

    // Write on a set, read on a poll
    always_ff @(posedge clk)
    begin
        if (cmd.set_alarm && id_ok)
        begin
            alarm_mem[aidx] <= '{length: len_in, start: total_ms};
        end
        if (cmd.poll && id_ok)
        begin
            rd_entry_reg <= alarm_mem[aidx];
        end
    end

    // Arm on a set, disarm when a poll finds the alarm rang
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < NUM_ALARMS; a++)
            begin
                armed_reg[a] <= 1'b0;
            end
        end
        else if (cmd.set_alarm && id_ok)
        begin
            armed_reg[aidx] <= 1'b1;
        end
        else if (rang)
        begin
            armed_reg[aidx] <= 1'b0;
        end
    end

    // Hold the status of the latest operation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_pend_reg <= 1'b0;
            status_reg    <= ST_NOT_RINGING;
        end
        else
        begin
            poll_pend_reg <= cmd.poll && id_ok;
            if (cmd.issue)
            begin
                status_reg <= (cmd.poll && !id_ok) ? ST_BAD_ID : ST_NOT_RINGING;
            end
            else if (rang)
            begin
                status_reg <= ST_RANG;
            end
        end
    end

    assign alarm_status = status_reg;

endmodule

/* rtl/core/tajt_job_bank.sv */
// Job bank: job counters in a 1R1W synchronous memory, swept one slot a cycle
// on each tick. Depends on tajt_pkg for the command struct and sizes.
module tajt_job_bank #(
    parameter int NUM_JOBS = tajt_pkg::DEF_NUM_JOBS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  tajt_pkg::cmd_t cmd,
    input  logic [9:0]     step,
    input  logic [3:0]     enable_mask,
    input  logic [31:0]    job_period [tajt_pkg::CFG_JOB_SLOTS],
    output logic           sweep_busy,
    output logic [3:0]     jobs_fired
);
    import tajt_pkg::*;

    localparam int JIDX_W = (NUM_JOBS > 1) ? $clog2(NUM_JOBS) : 1;
    localparam logic [JIDX_W-1:0] LAST = JIDX_W'(NUM_JOBS - 1);

    logic [31:0]       count_mem [NUM_JOBS];
    logic              valid_reg [NUM_JOBS];
    logic [31:0]       rd_data_reg;
    logic              rd_valid_reg;
    logic              active_reg;
    logic [JIDX_W-1:0] idx_reg;
    logic [3:0]        fired_reg;

    logic              rd_en;
    logic [JIDX_W-1:0] rd_addr;
    logic [1:0]        slot;
    logic [31:0]       cur;
    logic [32:0]       sum;
    logic [31:0]       sat;
    logic              slot_en;
    logic              fire;
    logic              restart_hit;
    logic              wr_en;
    logic [JIDX_W-1:0] wr_addr;
    logic [31:0]       wr_data;

    // Read the first slot on a tick, then one slot ahead of the update
    assign rd_en   = cmd.tick || (active_reg && (idx_reg != LAST));
    assign rd_addr = cmd.tick ? '0 : idx_reg + 1'b1;

    // Update the slot whose count was read last cycle
    assign slot    = 2'(idx_reg);
    assign cur     = rd_valid_reg ? rd_data_reg : '0;
    assign sum     = {1'b0, cur} + 33'(step);
    assign sat     = sum[32] ? '1 : sum[31:0];
    assign slot_en = active_reg && enable_mask[slot];
    assign fire    = sat >= job_period[slot];

    assign restart_hit = cmd.restart && ({1'b0, cmd.id} < 5'(NUM_JOBS));

    // Share the single write port between the sweep and a restart
    always_comb
    begin
        wr_en   = slot_en || restart_hit;
        wr_addr = idx_reg;
        wr_data = fire ? '0 : sat;
        if (restart_hit)
        begin
            wr_addr = cmd.id[JIDX_W-1:0];
            wr_data = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg  <= count_mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
        end
        if (wr_en)
        begin
            count_mem[wr_addr] <= wr_data;
        end
    end

    // Mark entries written since reset; unwritten ones read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < NUM_JOBS; j++)
            begin
                valid_reg[j] <= 1'b0;
            end
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Step the sweep and gather the fire mask
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            idx_reg    <= '0;
            fired_reg  <= '0;
        end
        else
        begin
            if (cmd.issue)
            begin
                fired_reg <= '0;
            end
            else if (slot_en && fire)
            begin
                fired_reg[slot] <= 1'b1;
            end
            if (cmd.tick)
            begin
                active_reg <= 1'b1;
                idx_reg    <= '0;
            end
            else if (active_reg)
            begin
                if (idx_reg == LAST)
                begin
                    active_reg <= 1'b0;
                end
                else
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
        end
    end

    assign sweep_busy = active_reg;
    assign jobs_fired = fired_reg;

endmodule

/* rtl/core/tajt_ctrl.sv */
// Sequencer: takes an operation, issues it to the banks, waits and raises done.
// Depends on tajt_pkg for the opcodes, states and command struct.
module tajt_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [2:0]     opcode,
    input  logic [3:0]     slot_id,
    input  logic [31:0]    duration,
    input  logic           in_seconds,
    input  logic           sweep_busy,
    output logic           busy,
    output logic           done,
    output tajt_pkg::cmd_t cmd
);
    import tajt_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic [2:0]  op_reg;
    logic [3:0]  id_reg;
    logic [31:0] dur_reg;
    logic        secs_reg;
    logic        accept;
    op_t         op;

    assign accept = start && !busy;
    assign op     = op_t'(op_reg);

    // Capture the operation on a transfer
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= opcode;
            id_reg   <= slot_id;
            dur_reg  <= duration;
            secs_reg <= in_seconds;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (accept)
                begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                if ((op == OP_TICK) || (op == OP_POLL))
                begin
                    state_next = CS_WAIT;
                end
                else
                begin
                    state_next = CS_DONE;
                end
            end
            CS_WAIT:
            begin
                if (!sweep_busy)
                begin
                    state_next = CS_DONE;
                end
            end
            CS_DONE:
            begin
                state_next = accept ? CS_EXEC : CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        busy           = 1'b0;
        done           = 1'b0;
        cmd            = '0;
        cmd.id         = id_reg;
        cmd.duration   = dur_reg;
        cmd.in_seconds = secs_reg;
        case (state_reg)
            CS_EXEC:
            begin
                busy      = 1'b1;
                cmd.issue = 1'b1;
                case (op)
                    OP_TICK:    cmd.tick      = 1'b1;
                    OP_SET:     cmd.set_alarm = 1'b1;
                    OP_POLL:    cmd.poll      = 1'b1;
                    OP_RESTART: cmd.restart   = 1'b1;
                    OP_CLEAR:   cmd.clear     = 1'b1;
                    default:    cmd.issue     = 1'b1;
                endcase
            end
            CS_WAIT:
            begin
                busy = 1'b1;
            end
            CS_DONE:
            begin
                done = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

endmodule
